// ----- hdl/env_sensor_compensation_core_defines.svh -----
// Assertion macros used by the sensor compensation core.
`ifndef ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/esc_pkg.sv -----
// Package with the shared types, constants and helpers of the sensor compensation core.
`default_nettype none
package esc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_PRESS_C = 3'd3,
        CFG_HUM     = 3'd4
    } t_cfg_idx;

    localparam int DIV_STEPS  = 64;
    localparam int ST_DV0     = 9;
    localparam int ST_DVL     = ST_DV0 + DIV_STEPS;
    localparam int ST_Q1      = ST_DVL + 1;
    localparam int ST_Q6      = ST_DVL + 6;
    localparam int ST_OUT     = ST_DVL + 7;
    localparam int PIPE_DEPTH = ST_OUT + 1;

    localparam logic [31:0] HUM_V_MAX  = 32'd419430400;
    localparam logic [16:0] HUM_Q_MAX  = 17'd102400;

    typedef struct packed {
        logic [23:0] tc;
        logic [31:0] hv;
        logic        zero;
        logic        neg;
    } t_dv_pay;

    function automatic logic [31:0] sra32(input logic [31:0] x, input logic [5:0] n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input logic [5:0] n);
        return $signed(x) >>> n;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/esc_in_if.sv -----
// Interface of the raw measurement channel.
`default_nettype none
interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_temp;
    logic [23:0] raw_press;
    logic [15:0] raw_hum;

    modport source (output valid, output raw_temp, output raw_press, output raw_hum,
                    input ready);
    modport sink (input valid, input raw_temp, input raw_press, input raw_hum,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/esc_out_if.sv -----
// Interface of the compensated result channel.
`default_nettype none
interface esc_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] temperature_centi;
    logic signed [23:0] pressure_pa;
    logic [16:0]        humidity_q10;

    modport source (output valid, output temperature_centi, output pressure_pa,
                    output humidity_q10, input ready);
    modport sink (input valid, input temperature_centi, input pressure_pa,
                  input humidity_q10, output ready);
endinterface
`default_nettype wire

// ----- hdl/env_sensor_compensation_core.sv -----
// A result passes stages 1 to 9, the divider stages and the post-division stages before it is offered.
// Throughput: one measurement per cycle while the output is not stalled; the 64-stage restoring divider of the
// pressure path is fully pipelined, and the whole pipeline holds while the output waits.
// Reset (i_rst_n low at a clock edge) clears all valid bits and all calibration
// registers to zero; datapath registers are not reset.
`default_nettype none
`include "env_sensor_compensation_core_defines.svh"
module env_sensor_compensation_core
    import esc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_wdata,
    esc_in_if.sink                i_in,
    esc_out_if.source             o_out
);

    logic [47:0] r_temp_calib;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_press_c;
    logic [63:0] r_hum_calib;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_a    <= '0;
            r_press_b    <= '0;
            r_press_c    <= '0;
            r_hum_calib  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TEMP:    r_temp_calib <= i_cfg_wdata[47:0];
                CFG_PRESS_A: r_press_a    <= i_cfg_wdata;
                CFG_PRESS_B: r_press_b    <= i_cfg_wdata;
                CFG_PRESS_C: r_press_c    <= i_cfg_wdata[15:0];
                CFG_HUM:     r_hum_calib  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    logic [15:0] w_t1, w_t2, w_t3;
    logic [15:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [7:0]  w_h1, w_h3, w_h6;
    logic [15:0] w_h2;
    logic [11:0] w_h4, w_h5;

    assign w_t1 = r_temp_calib[15:0];
    assign w_t2 = r_temp_calib[31:16];
    assign w_t3 = r_temp_calib[47:32];
    assign w_p1 = r_press_a[15:0];
    assign w_p2 = r_press_a[31:16];
    assign w_p3 = r_press_a[47:32];
    assign w_p4 = r_press_a[63:48];
    assign w_p5 = r_press_b[15:0];
    assign w_p6 = r_press_b[31:16];
    assign w_p7 = r_press_b[47:32];
    assign w_p8 = r_press_b[63:48];
    assign w_p9 = r_press_c;
    assign w_h1 = r_hum_calib[7:0];
    assign w_h2 = r_hum_calib[23:8];
    assign w_h3 = r_hum_calib[31:24];
    assign w_h4 = r_hum_calib[43:32];
    assign w_h5 = r_hum_calib[55:44];
    assign w_h6 = r_hum_calib[63:56];

    assign w_adv      = !r_vld[ST_OUT] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    // Stage 1
    logic [19:0] w_adt;
    logic [31:0] w_tx, w_d, w_dd;
    logic signed [47:0] w_tp;
    logic [31:0] r1_ta, r1_dd;
    logic [19:0] r1_adp;
    logic [15:0] r1_adh;

    assign w_adt = i_in.raw_temp[23:4];
    assign w_tx  = {15'd0, w_adt[19:3]} - {15'd0, w_t1, 1'b0};
    assign w_tp  = $signed(w_tx) * $signed(w_t2);
    assign w_d   = {16'd0, w_adt[19:4]} - {16'd0, w_t1};
    assign w_dd  = w_d * w_d;

    // Stage 2
    logic [31:0] w_dds;
    logic signed [47:0] w_m2;
    logic [31:0] r2_a, r2_m;
    logic [19:0] r2_adp;
    logic [15:0] r2_adh;

    assign w_dds = sra32(r1_dd, 6'd12);
    assign w_m2  = $signed(w_dds) * $signed(w_t3);

    // Stage 3
    logic [31:0] w_b3;
    logic [31:0] r3_tf;
    logic [19:0] r3_adp;
    logic [15:0] r3_adh;

    assign w_b3 = sra32(r2_m, 6'd14);

    // Stage 4
    logic [31:0] w_tf5, w_tc4;
    logic [23:0] r4_tc;
    logic [33:0] r4_v1;
    logic [31:0] r4_hv;
    logic [19:0] r4_adp;
    logic [15:0] r4_adh;

    assign w_tf5 = r3_tf * 32'd5 + 32'd128;
    assign w_tc4 = sra32(w_tf5, 6'd8);

    // Stage 5
    logic signed [67:0] w_v1sq;
    logic signed [49:0] w_v1p5, w_v1p2;
    logic signed [43:0] w_mh5;
    logic signed [39:0] w_y0;
    logic signed [40:0] w_z0;
    logic [63:0] r5_v1sq;
    logic [49:0] r5_v1p5, r5_v1p2;
    logic [31:0] r5_mh5, r5_y0, r5_z0;
    logic [23:0] r5_tc;
    logic [19:0] r5_adp;
    logic [15:0] r5_adh;

    assign w_v1sq = $signed(r4_v1) * $signed(r4_v1);
    assign w_v1p5 = $signed(r4_v1) * $signed(w_p5);
    assign w_v1p2 = $signed(r4_v1) * $signed(w_p2);
    assign w_mh5  = $signed(r4_hv) * $signed(w_h5);
    assign w_y0   = $signed(r4_hv) * $signed(w_h6);
    assign w_z0   = $signed(r4_hv) * $signed({1'b0, w_h3});

    // Stage 6
    logic signed [79:0] w_q6, w_q3;
    logic [31:0] w_xs;
    logic [63:0] r6_q6, r6_q3;
    logic [49:0] r6_v1p5, r6_v1p2;
    logic [31:0] r6_x, r6_y, r6_z;
    logic [23:0] r6_tc;
    logic [19:0] r6_adp;

    assign w_q6 = $signed(r5_v1sq) * $signed(w_p6);
    assign w_q3 = $signed(r5_v1sq) * $signed(w_p3);
    assign w_xs = {2'd0, r5_adh, 14'd0} - {w_h4, 20'd0} - r5_mh5 + 32'd16384;

    // Stage 7
    logic [63:0] w_v1p5x, w_v1p2x, w_q3s;
    logic [63:0] r7_v2, r7_v1b;
    logic [31:0] r7_yz, r7_x;
    logic [23:0] r7_tc;
    logic [19:0] r7_adp;

    assign w_v1p5x = {{14{r6_v1p5[49]}}, r6_v1p5};
    assign w_v1p2x = {{14{r6_v1p2[49]}}, r6_v1p2};
    assign w_q3s   = sra64(r6_q3, 6'd8);

    // Stage 8
    logic [63:0] w_s8, w_pr, w_pp;
    logic [31:0] w_yzs, w_w0a;
    logic signed [47:0] w_w0;
    logic [63:0] r8_pr, r8_nm;
    logic [31:0] r8_w0, r8_x;
    logic [23:0] r8_tc;

    assign w_s8  = 64'h0000_8000_0000_0000 + r7_v1b;
    assign w_pr  = w_s8 * {48'd0, w_p1};
    assign w_pp  = 64'd1048576 - {44'd0, r7_adp};
    assign w_yzs = sra32(r7_yz, 6'd10);
    assign w_w0a = w_yzs + 32'd2097152;
    assign w_w0  = $signed(w_w0a) * $signed(w_h2);

    // Stage 9
    logic [63:0] r9_den, r9_num;
    logic [31:0] r9_w, r9_x;
    logic [23:0] r9_tc;

    // Divider stages
    logic [63:0] r_dv_rem [0:DIV_STEPS];
    logic [63:0] r_dv_dq  [0:DIV_STEPS];
    logic [63:0] r_dv_den [0:DIV_STEPS];
    t_dv_pay     r_dv_pay [0:DIV_STEPS];
    logic [63:0] n_dv_rem [1:DIV_STEPS];
    logic [63:0] n_dv_dq  [1:DIV_STEPS];
    logic [31:0] w_hv10;

    assign w_hv10 = r9_x * r9_w;

    always_comb begin
        logic [64:0] v_tr;
        logic        v_ge;
        for (int j = 1; j <= DIV_STEPS; j++) begin
            v_tr = {r_dv_rem[j-1], r_dv_dq[j-1][63]};
            v_ge = v_tr >= {1'b0, r_dv_den[j-1]};
            n_dv_rem[j] = v_ge ? 64'(v_tr - {1'b0, r_dv_den[j-1]}) : v_tr[63:0];
            n_dv_dq[j]  = {r_dv_dq[j-1][62:0], v_ge};
        end
    end

    // Post-division stages
    logic [63:0] w_q1q;
    logic [31:0] w_s15;
    logic [63:0] r_q1_p;
    logic [31:0] r_q1_sqh, r_q1_hv;
    logic [23:0] r_q1_tc;
    logic        r_q1_zero;

    assign w_q1q = r_dv_dq[DIV_STEPS];
    assign w_s15 = sra32(r_dv_pay[DIV_STEPS].hv, 6'd15);

    logic [63:0] w_t13;
    logic signed [79:0] w_p8p;
    logic [31:0] w_sqhs;
    logic [63:0] r_q2_ll, r_q2_p8p, r_q2_p;
    logic [31:0] r_q2_cr, r_q2_k, r_q2_hv;
    logic [23:0] r_q2_tc;
    logic        r_q2_zero;

    assign w_t13  = sra64(r_q1_p, 6'd13);
    assign w_p8p  = $signed(r_q1_p) * $signed(w_p8);
    assign w_sqhs = sra32(r_q1_sqh, 6'd7);

    logic [31:0] w_ks, w_hv3;
    logic [63:0] r_q3_sq, r_q3_v2b, r_q3_p;
    logic [16:0] r_q3_hq;
    logic [23:0] r_q3_tc;
    logic        r_q3_zero;

    assign w_ks  = sra32(r_q2_k, 6'd4);
    assign w_hv3 = r_q2_hv - w_ks;

    logic signed [79:0] w_m4;
    logic [63:0] r_q4_m, r_q4_v2b, r_q4_p;
    logic [16:0] r_q4_hq;
    logic [23:0] r_q4_tc;
    logic        r_q4_zero;

    assign w_m4 = $signed(r_q3_sq) * $signed(w_p9);

    logic [63:0] w_ms;
    logic [63:0] r_q5_s;
    logic [16:0] r_q5_hq;
    logic [23:0] r_q5_tc;
    logic        r_q5_zero;

    assign w_ms = sra64(r_q4_m, 6'd25);

    logic [63:0] w_ss;
    logic [31:0] r_q6_p32;
    logic [16:0] r_q6_hq;
    logic [23:0] r_q6_tc;
    logic        r_q6_zero;

    assign w_ss = sra64(r_q5_s, 6'd8);

    logic [31:0] w_pb, w_pd;
    logic [23:0] r_q7_pres, r_q7_tc;
    logic [16:0] r_q7_hq;

    assign w_pb = r_q6_p32 + (r_q6_p32[31] ? 32'd255 : 32'd0);
    assign w_pd = sra32(w_pb, 6'd8);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ta  <= w_tp[31:0];
            r1_dd  <= w_dd;
            r1_adp <= i_in.raw_press[23:4];
            r1_adh <= i_in.raw_hum;

            r2_a   <= sra32(r1_ta, 6'd11);
            r2_m   <= w_m2[31:0];
            r2_adp <= r1_adp;
            r2_adh <= r1_adh;

            r3_tf  <= r2_a + w_b3;
            r3_adp <= r2_adp;
            r3_adh <= r2_adh;

            r4_tc  <= w_tc4[23:0];
            r4_v1  <= {{2{r3_tf[31]}}, r3_tf} - 34'd128000;
            r4_hv  <= r3_tf - 32'd76800;
            r4_adp <= r3_adp;
            r4_adh <= r3_adh;

            r5_v1sq <= w_v1sq[63:0];
            r5_v1p5 <= w_v1p5;
            r5_v1p2 <= w_v1p2;
            r5_mh5  <= w_mh5[31:0];
            r5_y0   <= w_y0[31:0];
            r5_z0   <= w_z0[31:0];
            r5_tc   <= r4_tc;
            r5_adp  <= r4_adp;
            r5_adh  <= r4_adh;

            r6_q6   <= w_q6[63:0];
            r6_q3   <= w_q3[63:0];
            r6_v1p5 <= r5_v1p5;
            r6_v1p2 <= r5_v1p2;
            r6_x    <= sra32(w_xs, 6'd15);
            r6_y    <= sra32(r5_y0, 6'd10);
            r6_z    <= sra32(r5_z0, 6'd11) + 32'd32768;
            r6_tc   <= r5_tc;
            r6_adp  <= r5_adp;

            r7_v2  <= r6_q6 + {w_v1p5x[46:0], 17'd0}
                      + {{13{w_p4[15]}}, w_p4, 35'd0};
            r7_v1b <= w_q3s + {w_v1p2x[51:0], 12'd0};
            r7_yz  <= r6_y * r6_z;
            r7_x   <= r6_x;
            r7_tc  <= r6_tc;
            r7_adp <= r6_adp;

            r8_pr <= w_pr;
            r8_nm <= {w_pp[32:0], 31'd0} - r7_v2;
            r8_w0 <= w_w0[31:0];
            r8_x  <= r7_x;
            r8_tc <= r7_tc;

            r9_den <= sra64(r8_pr, 6'd33);
            r9_num <= r8_nm * 64'd3125;
            r9_w   <= sra32(r8_w0 + 32'd8192, 6'd14);
            r9_x   <= r8_x;
            r9_tc  <= r8_tc;

            r_dv_rem[0]      <= '0;
            r_dv_dq[0]       <= r9_num[63] ? 64'd0 - r9_num : r9_num;
            r_dv_den[0]      <= r9_den[63] ? 64'd0 - r9_den : r9_den;
            r_dv_pay[0].tc   <= r9_tc;
            r_dv_pay[0].hv   <= w_hv10;
            r_dv_pay[0].zero <= r9_den == 64'd0;
            r_dv_pay[0].neg  <= r9_num[63] ^ r9_den[63];
            for (int j = 1; j <= DIV_STEPS; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_dq[j]  <= n_dv_dq[j];
                r_dv_den[j] <= r_dv_den[j-1];
                r_dv_pay[j] <= r_dv_pay[j-1];
            end

            r_q1_p    <= r_dv_pay[DIV_STEPS].neg ? 64'd0 - w_q1q : w_q1q;
            r_q1_sqh  <= w_s15 * w_s15;
            r_q1_hv   <= r_dv_pay[DIV_STEPS].hv;
            r_q1_tc   <= r_dv_pay[DIV_STEPS].tc;
            r_q1_zero <= r_dv_pay[DIV_STEPS].zero;

            r_q2_ll   <= {32'd0, w_t13[31:0]} * {32'd0, w_t13[31:0]};
            r_q2_cr   <= w_t13[31:0] * w_t13[63:32];
            r_q2_p8p  <= w_p8p[63:0];
            r_q2_p    <= r_q1_p;
            r_q2_k    <= w_sqhs * {24'd0, w_h1};
            r_q2_hv   <= r_q1_hv;
            r_q2_tc   <= r_q1_tc;
            r_q2_zero <= r_q1_zero;

            r_q3_sq  <= r_q2_ll + {r_q2_cr[30:0], 33'd0};
            r_q3_v2b <= sra64(r_q2_p8p, 6'd19);
            r_q3_p   <= r_q2_p;
            if (w_hv3[31]) begin
                r_q3_hq <= '0;
            end else if (w_hv3 > HUM_V_MAX) begin
                r_q3_hq <= HUM_Q_MAX;
            end else begin
                r_q3_hq <= w_hv3[28:12];
            end
            r_q3_tc   <= r_q2_tc;
            r_q3_zero <= r_q2_zero;

            r_q4_m    <= w_m4[63:0];
            r_q4_v2b  <= r_q3_v2b;
            r_q4_p    <= r_q3_p;
            r_q4_hq   <= r_q3_hq;
            r_q4_tc   <= r_q3_tc;
            r_q4_zero <= r_q3_zero;

            r_q5_s    <= r_q4_p + w_ms + r_q4_v2b;
            r_q5_hq   <= r_q4_hq;
            r_q5_tc   <= r_q4_tc;
            r_q5_zero <= r_q4_zero;

            r_q6_p32  <= w_ss[31:0] + {{12{w_p7[15]}}, w_p7, 4'd0};
            r_q6_hq   <= r_q5_hq;
            r_q6_tc   <= r_q5_tc;
            r_q6_zero <= r_q5_zero;

            r_q7_pres <= r_q6_zero ? 24'd0 : w_pd[23:0];
            r_q7_hq   <= r_q6_hq;
            r_q7_tc   <= r_q6_tc;
        end
    end

    assign o_out.valid             = r_vld[ST_OUT];
    assign o_out.temperature_centi = r_q7_tc;
    assign o_out.pressure_pa       = r_q7_pres;
    assign o_out.humidity_q10      = r_q7_hq;

    `ESC_ASSERT_NEXT(a_zero_div_press, i_clk, i_rst_n, w_adv && r_vld[ST_Q6] && r_q6_zero, o_out.pressure_pa == 24'd0, "zero divisor did not give zero pressure")
    `ESC_ASSERT_SAME(a_hum_range, i_clk, i_rst_n, o_out.valid, o_out.humidity_q10 <= HUM_Q_MAX, "humidity above its clamp")
    `ESC_ASSERT_SAME(a_div_rem, i_clk, i_rst_n, r_vld[ST_DVL] && r_dv_den[DIV_STEPS] != 64'd0, r_dv_rem[DIV_STEPS] < r_dv_den[DIV_STEPS], "divider remainder not below divisor")
    `ESC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_adv, $stable(r_vld), "pipeline moved while stalled")

endmodule
`default_nettype wire

// ----- dv/tb_env_sensor_compensation_core.sv -----
// Self-checking testbench of the sensor compensation core: directed and random measurements.
`default_nettype none
module tb_env_sensor_compensation_core;
    import esc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;
    localparam int N_CFG     = 5;
    localparam int DRAIN_CYC = 100;

    typedef enum int {SET_RESET, SET_TYPICAL, SET_NO_DIVISOR, SET_ONES, SET_NUDGED,
                      SET_RANDOM, SET_ZERO} t_cal_set;

    typedef struct packed {
        logic [23:0] tc;
        logic [23:0] pa;
        logic [16:0] hq;
    } t_reading;

    typedef struct {
        t_cal_set    cal;
        logic [23:0] rt;
        logic [23:0] rp;
        logic [15:0] rh;
        bit          known;
        t_reading    res;
    } t_row;

    localparam logic [63:0] TYP_TEMP    = 64'h0000_FC18_6743_6B70;
    localparam logic [63:0] TYP_PRESS_A = 64'h0B27_0BD0_D643_8E7D;
    localparam logic [63:0] TYP_PRESS_B = 64'hC6F8_3C8C_FFF9_008C;
    localparam logic [63:0] TYP_PRESS_C = 64'h0000_0000_0000_1770;
    localparam logic [63:0] TYP_HUM     = 64'h1E03_2139_0001_6A4B;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    esc_in_if  meas_ch ();
    esc_out_if res_ch ();

    env_sensor_compensation_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (meas_ch.sink),
        .o_out       (res_ch.source)
    );

    logic [63:0] cal_regs [N_CFG];
    t_reading    pending_readings [$];
    int          n_errors;
    bit          no_idle;
    int          ready_hold;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #20ms;
        $display("tb_env_sensor_compensation_core: errors");
        $finish;
    end

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic t_reading compensate(input logic [23:0] rt, input logic [23:0] rp,
                                            input logic [15:0] rh);
        logic [31:0] adt, t1, t2, t3, ta, td, tb, tf, tcent;
        logic [63:0] adp, p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, pw;
        logic [31:0] pw32, pres;
        logic [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, hz, hw;
        t_reading    r;
        adt   = {12'd0, rt[23:4]};
        t1    = {16'd0, cal_regs[CFG_TEMP][15:0]};
        t2    = 32'(sext16(cal_regs[CFG_TEMP][31:16]));
        t3    = 32'(sext16(cal_regs[CFG_TEMP][47:32]));
        ta    = asr32(((adt >> 3) - (t1 << 1)) * t2, 11);
        td    = (adt >> 4) - t1;
        tb    = asr32(asr32(td * td, 12) * t3, 14);
        tf    = ta + tb;
        tcent = asr32(tf * 32'd5 + 32'd128, 8);

        adp = {44'd0, rp[23:4]};
        p1  = {48'd0, cal_regs[CFG_PRESS_A][15:0]};
        p2  = sext16(cal_regs[CFG_PRESS_A][31:16]);
        p3  = sext16(cal_regs[CFG_PRESS_A][47:32]);
        p4  = sext16(cal_regs[CFG_PRESS_A][63:48]);
        p5  = sext16(cal_regs[CFG_PRESS_B][15:0]);
        p6  = sext16(cal_regs[CFG_PRESS_B][31:16]);
        p7  = sext16(cal_regs[CFG_PRESS_B][47:32]);
        p8  = sext16(cal_regs[CFG_PRESS_B][63:48]);
        p9  = sext16(cal_regs[CFG_PRESS_C][15:0]);
        v1  = {{32{tf[31]}}, tf} - 64'd128000;
        v2  = v1 * v1 * p6;
        v2  = v2 + ((v1 * p5) << 17);
        v2  = v2 + (p4 << 35);
        v1  = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1  = asr64(((64'd1 << 47) + v1) * p1, 33);
        pres = 32'd0;
        if (v1 != 64'd0) begin
            pw   = 64'd1048576 - adp;
            pw   = quot64(((pw << 31) - v2) * 64'd3125, v1);
            v1   = asr64(p9 * asr64(pw, 13) * asr64(pw, 13), 25);
            v2   = asr64(p8 * pw, 19);
            pw   = asr64(pw + v1 + v2, 8) + (p7 << 4);
            pw32 = pw[31:0];
            pres = pw32[31] ? -((-pw32) >> 8) : (pw32 >> 8);
        end

        h1 = {24'd0, cal_regs[CFG_HUM][7:0]};
        h2 = {{16{cal_regs[CFG_HUM][23]}}, cal_regs[CFG_HUM][23:8]};
        h3 = {24'd0, cal_regs[CFG_HUM][31:24]};
        h4 = {{20{cal_regs[CFG_HUM][43]}}, cal_regs[CFG_HUM][43:32]};
        h5 = {{20{cal_regs[CFG_HUM][55]}}, cal_regs[CFG_HUM][55:44]};
        h6 = {{24{cal_regs[CFG_HUM][63]}}, cal_regs[CFG_HUM][63:56]};
        hv = tf - 32'd76800;
        hx = asr32(({16'd0, rh} << 14) - (h4 << 20) - h5 * hv + 32'd16384, 15);
        hy = asr32(hv * h6, 10);
        hz = asr32(hv * h3, 11) + 32'd32768;
        hw = asr32((asr32(hy * hz, 10) + 32'd2097152) * h2 + 32'd8192, 14);
        hv = hx * hw;
        hv = hv - asr32(asr32(asr32(hv, 15) * asr32(hv, 15), 7) * h1, 4);
        if (hv[31]) begin
            hv = 32'd0;
        end else if (hv > HUM_V_MAX) begin
            hv = HUM_V_MAX;
        end

        r.tc = tcent[23:0];
        r.pa = pres[23:0];
        r.hq = hv[28:12];
        return r;
    endfunction

    function automatic void flag_error(input string what);
        n_errors++;
        if (n_errors <= 10) begin
            $display("mismatch: %s", what);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_TEMP:    cal_regs[CFG_TEMP]    = data & 64'h0000_FFFF_FFFF_FFFF;
            CFG_PRESS_A: cal_regs[CFG_PRESS_A] = data;
            CFG_PRESS_B: cal_regs[CFG_PRESS_B] = data;
            CFG_PRESS_C: cal_regs[CFG_PRESS_C] = data & 64'h0000_0000_0000_FFFF;
            CFG_HUM:     cal_regs[CFG_HUM]     = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_calibration(input t_cal_set set);
        logic [63:0] vals [N_CFG];
        logic [63:0] nudge;
        wait (pending_readings.size() == 0);
        case (set)
            SET_TYPICAL, SET_NO_DIVISOR, SET_NUDGED: begin
                vals[CFG_TEMP]    = TYP_TEMP;
                vals[CFG_PRESS_A] = TYP_PRESS_A;
                vals[CFG_PRESS_B] = TYP_PRESS_B;
                vals[CFG_PRESS_C] = TYP_PRESS_C;
                vals[CFG_HUM]     = TYP_HUM;
                if (set == SET_NO_DIVISOR) begin
                    vals[CFG_PRESS_A][15:0] = 16'd0;
                end
                if (set == SET_NUDGED) begin
                    for (int i = 0; i < N_CFG; i++) begin
                        nudge = rand64() & 64'h003F_003F_003F_003F;
                        vals[i] = vals[i] ^ nudge;
                    end
                end
            end
            SET_ONES: begin
                for (int i = 0; i < N_CFG; i++) vals[i] = '1;
            end
            SET_RANDOM: begin
                for (int i = 0; i < N_CFG; i++) vals[i] = rand64();
            end
            default: begin
                for (int i = 0; i < N_CFG; i++) vals[i] = '0;
            end
        endcase
        for (int i = 0; i < N_CFG; i++) begin
            write_reg(i[CFG_IDX_W-1:0], vals[i]);
        end
        write_reg(CFG_SPARE_FIRST, rand64());
        write_reg(CFG_SPARE_LAST, '1);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_measurement(input logic [23:0] rt, input logic [23:0] rp,
                                    input logic [15:0] rh, input bit known,
                                    input t_reading res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        meas_ch.valid     <= 1'b1;
        meas_ch.raw_temp  <= rt;
        meas_ch.raw_press <= rp;
        meas_ch.raw_hum   <= rh;
        forever begin
            @(negedge i_clk);
            if (meas_ch.ready) break;
        end
        pending_readings.push_back(known ? res : compensate(rt, rp, rh));
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int roll;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            ready_hold = 0;
        end else if (no_idle) begin
            res_ch.ready <= 1'b1;
        end else if (ready_hold > 0) begin
            res_ch.ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll == 0) begin
                res_ch.ready <= 1'b0;
                ready_hold = $urandom_range(8, 40);
            end else if (roll < 16) begin
                res_ch.ready <= 1'b0;
            end else if (roll < 21) begin
                res_ch.ready <= ($urandom_range(0, 3) == 0);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        t_reading want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_readings.size() == 0) begin
                flag_error("result transfer with nothing outstanding");
            end else begin
                want = pending_readings.pop_front();
                if (res_ch.temperature_centi !== want.tc)
                    flag_error($sformatf("temperature exp %0d got %0d",
                        $signed(want.tc), res_ch.temperature_centi));
                if (res_ch.pressure_pa !== want.pa)
                    flag_error($sformatf("pressure exp %0d got %0d",
                        $signed(want.pa), res_ch.pressure_pa));
                if (res_ch.humidity_q10 !== want.hq)
                    flag_error($sformatf("humidity exp %0d got %0d",
                        want.hq, res_ch.humidity_q10));
            end
        end
    end

    initial begin
        t_row        rows [$];
        t_cal_set    cur;
        t_cal_set    phase_set;
        t_reading    zero_res;
        logic [23:0] rt, rp;
        logic [15:0] rh;
        int          sel;

        n_errors = 0;
        no_idle = 1'b0;
        zero_res = '0;
        for (int i = 0; i < N_CFG; i++) cal_regs[i] = '0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        meas_ch.valid = 1'b0;
        meas_ch.raw_temp = '0;
        meas_ch.raw_press = '0;
        meas_ch.raw_hum = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All coefficients clear after reset, so every field comes out as zero.
        rows.push_back('{SET_RESET, 24'h000000, 24'h000000, 16'h0000, 1'b1, zero_res});
        rows.push_back('{SET_RESET, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, zero_res});
        rows.push_back('{SET_RESET, 24'h80000F, 24'h7FFFF0, 16'h8000, 1'b1, zero_res});
        rows.push_back('{SET_RESET, 24'h7EED00, 24'h655AC0, 16'h6667, 1'b1, zero_res});
        rows.push_back('{SET_TYPICAL, 24'h7EED00, 24'h655AC0, 16'h6667, 1'b0, zero_res});
        rows.push_back('{SET_TYPICAL, 24'h000000, 24'h000000, 16'h0000, 1'b0, zero_res});
        rows.push_back('{SET_TYPICAL, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0, zero_res});
        rows.push_back('{SET_TYPICAL, 24'h82000A, 24'h3FFFF5, 16'hFFFF, 1'b0, zero_res});
        rows.push_back('{SET_TYPICAL, 24'h6B7000, 24'hFFFFF0, 16'h0001, 1'b0, zero_res});
        rows.push_back('{SET_TYPICAL, 24'h5A0000, 24'h400000, 16'h8000, 1'b0, zero_res});
        rows.push_back('{SET_TYPICAL, 24'hC00000, 24'h00000F, 16'h7FFF, 1'b0, zero_res});
        rows.push_back('{SET_NO_DIVISOR, 24'h7EED00, 24'h655AC0, 16'h6667, 1'b0, zero_res});
        rows.push_back('{SET_NO_DIVISOR, 24'hFFFFFF, 24'h000000, 16'hFFFF, 1'b0, zero_res});
        rows.push_back('{SET_ONES, 24'h000000, 24'h000000, 16'h0000, 1'b0, zero_res});
        rows.push_back('{SET_ONES, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0, zero_res});
        rows.push_back('{SET_ONES, 24'h123456, 24'hABCDEF, 16'h5A5A, 1'b0, zero_res});

        cur = SET_RESET;
        foreach (rows[i]) begin
            if (rows[i].cal != cur) begin
                meas_ch.valid <= 1'b0;
                load_calibration(rows[i].cal);
                cur = rows[i].cal;
            end
            send_measurement(rows[i].rt, rows[i].rp, rows[i].rh, rows[i].known,
                             rows[i].res);
        end

        for (int ph = 0; ph < 8; ph++) begin
            meas_ch.valid <= 1'b0;
            case (ph)
                0, 3:    phase_set = SET_TYPICAL;
                1, 4, 6: phase_set = SET_NUDGED;
                2:       phase_set = SET_RANDOM;
                5:       phase_set = SET_NO_DIVISOR;
                default: phase_set = SET_ONES;
            endcase
            load_calibration(phase_set);
            for (int k = 0; k < 175; k++) begin
                if ($urandom_range(0, 59) == 0) no_idle = !no_idle;
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    // Realistic readings around room conditions with random low bits.
                    rt = {20'($urandom_range(20'h60000, 20'h9FFFF)),
                          4'($urandom_range(0, 15))};
                    rp = {20'($urandom_range(20'h40000, 20'h80000)),
                          4'($urandom_range(0, 15))};
                    rh = 16'($urandom_range(16'h3000, 16'hA000));
                end else begin
                    rt = 24'($urandom());
                    rp = 24'($urandom());
                    rh = 16'($urandom());
                end
                send_measurement(rt, rp, rh, 1'b0, zero_res);
            end
        end
        meas_ch.valid <= 1'b0;
        no_idle = 1'b0;

        wait (pending_readings.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_env_sensor_compensation_core: clean");
        end else begin
            $display("tb_env_sensor_compensation_core: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
